// ===== design/lcg_with_stride_skip_ahead_macros.svh =====
// Assertion macros shared by the checker of the generator block.
`ifndef LCG_WITH_STRIDE_SKIP_AHEAD_MACROS_SVH
`define LCG_WITH_STRIDE_SKIP_AHEAD_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define LCGSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LCGSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lcgsa_pkg.sv =====
// Shared constants and register codes for the generator block.
package lcgsa_pkg;

  localparam int STATE_BITS_DEF = 48;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int IDX_W          = 48;
  localparam int VAL_W          = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd3;

  localparam logic MODE_DRAW    = 1'b0;
  localparam logic MODE_HISTORY = 1'b1;

  localparam logic [CFG_W-1:0] MULT_RST   = 48'd19073486328125;
  localparam logic [CFG_W-1:0] INC_RST    = 48'd0;
  localparam logic [CFG_W-1:0] INIT_RST   = 48'd19073486328125;
  localparam logic [CFG_W-1:0] STRIDE_RST = 48'd152917;

endpackage

// ===== design/lcgsa_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface lcgsa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lcgsa_pkg::IDX_W-1:0] history_index;

  modport source (output valid, output mode, output history_index, input ready);
  modport sink (input valid, input mode, input history_index, output ready);
endinterface

interface lcgsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcgsa_pkg::VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== design/lcg_with_stride_skip_ahead.sv =====
// Top level: LCG draws and history starts with stride skip-ahead around one multiply-add unit.
// A draw, or a history start that follows the last index, needs one multiply-add; the next
// transfer in waits until the result is registered, and a stalled result holds off the input.
// Any other history start runs the squaring loop twice, for the stride and then for the skip:
// every set bit of a skip count needs four multiply-adds and every clear bit two of them.
// Synchronous active-low reset loads register defaults, clears seeds and last index, identity stride.
module lcg_with_stride_skip_ahead #(
  parameter int STATE_BITS = lcgsa_pkg::STATE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lcgsa_in_if.sink                        in_chan,
  lcgsa_out_if.source                     out_chan,
  input  logic                            cfg_we,
  input  logic [lcgsa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lcgsa_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SW = STATE_BITS;
  localparam int VW = lcgsa_pkg::VAL_W;
  localparam int IW = lcgsa_pkg::IDX_W;
  localparam int CW = lcgsa_pkg::CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DRAW, S_NEXT, S_KMUL, S_LOOP, S_GMUL, S_CMUL, S_CSTEP, S_GSQ, S_FIN, S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] mult_r, inc_r, init_r, stride_r;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] hs_r, hs_nxt;
  logic [SW-1:0] sm_r, sm_nxt;
  logic [SW-1:0] sa_r, sa_nxt;
  logic [SW-1:0] big_g_r, big_g_nxt;
  logic [SW-1:0] big_c_r, big_c_nxt;
  logic [SW-1:0] g_r, g_nxt;
  logic [SW-1:0] c_r, c_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [SW-1:0] kidx_r, kidx_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic          have_r, have_nxt;
  logic          run_r, run_nxt;
  logic [VW-1:0] result_r, result_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_value_r, out_value_nxt;
  logic          go_r, go_nxt;

  logic [SW-1:0]    mult_s, inc_s, init_s, stride_s;
  logic [SW+VW-1:0] frac_ext;
  logic [VW-1:0]    frac;
  logic             in_xfer;
  logic             consec;
  logic [SW-1:0]    mac_a, mac_b, mac_add, mac_res;
  logic             mac_done;

  assign mult_s   = SW'(mult_r);
  assign inc_s    = SW'(inc_r);
  assign init_s   = SW'(init_r);
  assign stride_s = SW'(stride_r);

  // The seed read as a 0.48 fraction: its top bits, padded with zeros when it is narrower.
  assign frac_ext = {cur_r, {VW{1'b0}}};
  assign frac     = frac_ext[SW+VW-1 -: VW];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && (state_r == S_IDLE);
  assign consec        = have_r && (in_chan.history_index != '0)
                         && (last_r == in_chan.history_index - IW'(1));

  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;

  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_add = '0;
    case (state_r)
      S_DRAW: begin
        mac_a   = mult_s;
        mac_b   = cur_r;
        mac_add = inc_s;
      end
      S_NEXT: begin
        mac_a   = sm_r;
        mac_b   = hs_r;
        mac_add = sa_r;
      end
      S_KMUL: begin
        mac_a = stride_s;
        mac_b = SW'(idx_r);
      end
      S_GMUL: begin
        mac_a = big_g_r;
        mac_b = g_r;
      end
      S_CMUL: begin
        mac_a   = big_c_r;
        mac_b   = g_r;
        mac_add = c_r;
      end
      S_CSTEP: begin
        mac_a = g_r + SW'(1);
        mac_b = c_r;
      end
      S_GSQ: begin
        mac_a = g_r;
        mac_b = g_r;
      end
      S_FIN: begin
        mac_a   = big_g_r;
        mac_b   = init_s;
        mac_add = big_c_r;
      end
      default: mac_a = '0;
    endcase
  end

  lcgsa_mac #(.SW(SW)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go_r),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .done   (mac_done),
    .result (mac_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    hs_nxt        = hs_r;
    sm_nxt        = sm_r;
    sa_nxt        = sa_r;
    big_g_nxt     = big_g_r;
    big_c_nxt     = big_c_r;
    g_nxt         = g_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    kidx_nxt      = kidx_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    run_nxt       = run_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt = in_chan.history_index;
          if (in_chan.mode == lcgsa_pkg::MODE_DRAW) begin
            result_nxt = frac;
            state_nxt  = S_DRAW;
          end else begin
            last_nxt  = in_chan.history_index;
            have_nxt  = 1'b1;
            state_nxt = consec ? S_NEXT : S_KMUL;
          end
        end
      end
      S_DRAW: begin
        if (mac_done) begin
          cur_nxt   = mac_res;
          state_nxt = S_OUT;
        end
      end
      S_NEXT, S_FIN: begin
        if (mac_done) begin
          hs_nxt     = mac_res;
          cur_nxt    = mac_res;
          result_nxt = VW'(mac_res);
          state_nxt  = S_OUT;
        end
      end
      S_KMUL: begin
        if (mac_done) begin
          kidx_nxt  = mac_res;
          k_nxt     = stride_s;
          g_nxt     = mult_s;
          c_nxt     = inc_s;
          big_g_nxt = SW'(1);
          big_c_nxt = '0;
          run_nxt   = 1'b0;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        // The first pass yields the stride parameters, the second the skip to the history.
        if (k_r == '0) begin
          if (!run_r) begin
            sm_nxt    = big_g_r;
            sa_nxt    = big_c_r;
            k_nxt     = kidx_r;
            g_nxt     = mult_s;
            c_nxt     = inc_s;
            big_g_nxt = SW'(1);
            big_c_nxt = '0;
            run_nxt   = 1'b1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = k_r[0] ? S_GMUL : S_CSTEP;
        end
      end
      S_GMUL: begin
        if (mac_done) begin
          big_g_nxt = mac_res;
          state_nxt = S_CMUL;
        end
      end
      S_CMUL: begin
        if (mac_done) begin
          big_c_nxt = mac_res;
          state_nxt = S_CSTEP;
        end
      end
      S_CSTEP: begin
        if (mac_done) begin
          c_nxt     = mac_res;
          state_nxt = S_GSQ;
        end
      end
      S_GSQ: begin
        if (mac_done) begin
          g_nxt     = mac_res;
          k_nxt     = k_r >> 1;
          state_nxt = S_LOOP;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    case (state_nxt)
      S_DRAW, S_NEXT, S_KMUL, S_GMUL, S_CMUL, S_CSTEP, S_GSQ, S_FIN:
        go_nxt = (state_nxt != state_r);
      default: go_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      hs_r        <= '0;
      sm_r        <= SW'(1);
      sa_r        <= '0;
      last_r      <= '0;
      have_r      <= 1'b0;
      run_r       <= 1'b0;
      mult_r      <= lcgsa_pkg::MULT_RST;
      inc_r       <= lcgsa_pkg::INC_RST;
      init_r      <= lcgsa_pkg::INIT_RST;
      stride_r    <= lcgsa_pkg::STRIDE_RST;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      hs_r        <= hs_nxt;
      sm_r        <= sm_nxt;
      sa_r        <= sa_nxt;
      last_r      <= last_nxt;
      have_r      <= have_nxt;
      run_r       <= run_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          lcgsa_pkg::REG_MULT:   mult_r   <= cfg_data;
          lcgsa_pkg::REG_INC:    inc_r    <= cfg_data;
          lcgsa_pkg::REG_INIT:   init_r   <= cfg_data;
          lcgsa_pkg::REG_STRIDE: stride_r <= cfg_data;
          default:               mult_r   <= mult_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    big_g_r     <= big_g_nxt;
    big_c_r     <= big_c_nxt;
    g_r         <= g_nxt;
    c_r         <= c_nxt;
    k_r         <= k_nxt;
    kidx_r      <= kidx_nxt;
    idx_r       <= idx_nxt;
    result_r    <= result_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

// ===== design/lcgsa_mac.sv =====
// Shared multiply-add unit: (a*b + addend) mod 2^SW using one half-width multiplier.
module lcgsa_mac #(
  parameter int SW = lcgsa_pkg::STATE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] a,
  input  logic [SW-1:0] b,
  input  logic [SW-1:0] addend,
  output logic          done,
  output logic [SW-1:0] result
);

  localparam int HW = (SW + 1) / 2;
  localparam int PW = 2 * HW;

  typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_P3} mstate_t;

  mstate_t       mstate_r;
  logic          done_r;
  logic [PW-1:0] a_r;
  logic [PW-1:0] b_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] prod_r;

  logic [HW-1:0] mul_x;
  logic [HW-1:0] mul_y;
  logic [PW-1:0] mul_p;
  logic [PW-1:0] prod_shl;

  // The low product and the two cross products go through the one multiplier in turn;
  // the high-by-high product lies wholly above the modulus and is never formed.
  assign mul_x    = (mstate_r == M_P2) ? a_r[PW-1:HW] : a_r[HW-1:0];
  assign mul_y    = (mstate_r == M_P1) ? b_r[PW-1:HW] : b_r[HW-1:0];
  assign mul_p    = PW'(mul_x) * PW'(mul_y);
  assign prod_shl = {prod_r[HW-1:0], {HW{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstate_r <= M_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (mstate_r)
        M_IDLE: begin
          if (start) begin
            mstate_r <= M_P0;
          end
        end
        M_P0:    mstate_r <= M_P1;
        M_P1:    mstate_r <= M_P2;
        M_P2:    mstate_r <= M_P3;
        M_P3: begin
          mstate_r <= M_IDLE;
          done_r   <= 1'b1;
        end
        default: mstate_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (mstate_r)
      M_IDLE: begin
        if (start) begin
          a_r   <= PW'(a);
          b_r   <= PW'(b);
          acc_r <= PW'(addend);
        end
      end
      M_P0: prod_r <= mul_p;
      M_P1: begin
        acc_r  <= acc_r + prod_r;
        prod_r <= mul_p;
      end
      M_P2: begin
        acc_r  <= acc_r + prod_shl;
        prod_r <= mul_p;
      end
      M_P3:    acc_r <= acc_r + prod_shl;
      default: acc_r <= acc_r;
    endcase
  end

  assign done   = done_r;
  assign result = acc_r[SW-1:0];

endmodule

// ===== design/lcgsa_checker.sv =====
// Port-level checker for the generator block and its bind to the top level.
`include "lcg_with_stride_skip_ahead_macros.svh"

module lcgsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lcgsa_pkg::VAL_W-1:0] out_value
);

  `LCGSA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result withdrawn while stalled")
  `LCGSA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_value), "stalled result changed")
  `LCGSA_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `LCGSA_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind lcg_with_stride_skip_ahead lcgsa_checker u_lcgsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.value)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the LCG block with stride skip-ahead.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lcgsa_pkg::VAL_W-1:0] ALL_ONES = {lcgsa_pkg::VAL_W{1'b1}};

  typedef struct packed {
    logic [lcgsa_pkg::VAL_W-1:0] g;
    logic [lcgsa_pkg::VAL_W-1:0] c;
  } affine_t;

  typedef struct {
    logic                        mode;
    logic [lcgsa_pkg::IDX_W-1:0] idx;
    bit                          known;
    logic [lcgsa_pkg::VAL_W-1:0] value;
  } vector_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lcgsa_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lcgsa_pkg::CFG_W-1:0]     cfg_data;

  lcgsa_in_if  in_ch();
  lcgsa_out_if out_ch();

  lcg_with_stride_skip_ahead DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the generator: registers and state.
  logic [lcgsa_pkg::VAL_W-1:0] gen_mult   = lcgsa_pkg::MULT_RST;
  logic [lcgsa_pkg::VAL_W-1:0] gen_inc    = lcgsa_pkg::INC_RST;
  logic [lcgsa_pkg::VAL_W-1:0] gen_seed0  = lcgsa_pkg::INIT_RST;
  logic [lcgsa_pkg::VAL_W-1:0] gen_stride = lcgsa_pkg::STRIDE_RST;
  logic [lcgsa_pkg::VAL_W-1:0] cur_seed   = '0;
  logic [lcgsa_pkg::VAL_W-1:0] hist_seed  = '0;
  logic [lcgsa_pkg::VAL_W-1:0] stride_g   = 48'd1;
  logic [lcgsa_pkg::VAL_W-1:0] stride_c   = '0;
  logic [lcgsa_pkg::IDX_W-1:0] last_idx   = '0;
  bit                          have_last  = 1'b0;

  logic [lcgsa_pkg::VAL_W-1:0] awaited_values[$];
  logic [lcgsa_pkg::VAL_W-1:0] want;
  int unsigned                 mismatches = 0;

  // Sender pacing and the history run being walked.
  int unsigned                 burst_left = 0;
  bit                          steady     = 1'b0;
  logic [lcgsa_pkg::IDX_W-1:0] run_idx    = '0;
  int unsigned                 run_left   = 0;

  vector_t directed_rows [21] = '{
    '{lcgsa_pkg::MODE_DRAW,    48'd0,              1'b1, 48'd0},
    '{lcgsa_pkg::MODE_DRAW,    ALL_ONES,           1'b1, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd1,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd2,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_DRAW,    48'd0,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_DRAW,    48'h123456789ABC,   1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd0,              1'b1, lcgsa_pkg::INIT_RST},
    '{lcgsa_pkg::MODE_DRAW,    48'd0,              1'b1, lcgsa_pkg::INIT_RST},
    '{lcgsa_pkg::MODE_HISTORY, 48'd0,              1'b1, lcgsa_pkg::INIT_RST},
    '{lcgsa_pkg::MODE_HISTORY, 48'd1,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, ALL_ONES,           1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd0,              1'b1, lcgsa_pkg::INIT_RST},
    '{lcgsa_pkg::MODE_HISTORY, 48'hFFFF_FFFF_FFFE, 1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, ALL_ONES,           1'b0, 48'd0},
    '{lcgsa_pkg::MODE_DRAW,    ALL_ONES,           1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'h8000_0000_0000, 1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'h5555_5555_5555, 1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'hAAAA_AAAA_AAAA, 1'b0, 48'd0},
    '{lcgsa_pkg::MODE_DRAW,    48'd0,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd3,              1'b0, 48'd0},
    '{lcgsa_pkg::MODE_HISTORY, 48'd4,              1'b0, 48'd0}
  };

  // Affine map of n generator steps, built by repeated squaring.
  function automatic affine_t skip_ahead(input logic [lcgsa_pkg::VAL_W-1:0] n);
    logic [lcgsa_pkg::VAL_W-1:0] k;
    logic [lcgsa_pkg::VAL_W-1:0] g;
    logic [lcgsa_pkg::VAL_W-1:0] c;
    affine_t                     acc;
    k = n;
    g = gen_mult;
    c = gen_inc;
    acc.g = 48'd1;
    acc.c = '0;
    while (k != 0) begin
      if (k[0]) begin
        acc.g = acc.g * g;
        acc.c = acc.c * g + c;
      end
      c = (g + 48'd1) * c;
      g = g * g;
      k = k >> 1;
    end
    return acc;
  endfunction

  function automatic logic [lcgsa_pkg::VAL_W-1:0] lcg_response(input logic m,
      input logic [lcgsa_pkg::IDX_W-1:0] idx);
    affine_t                     jump;
    logic [lcgsa_pkg::VAL_W-1:0] drawn;
    if (m == lcgsa_pkg::MODE_DRAW) begin
      drawn = cur_seed;
      cur_seed = gen_mult * cur_seed + gen_inc;
      return drawn;
    end
    if (have_last && idx != 0 && last_idx == idx - 48'd1) begin
      hist_seed = stride_g * hist_seed + stride_c;
    end else begin
      jump = skip_ahead(gen_stride);
      stride_g = jump.g;
      stride_c = jump.c;
      jump = skip_ahead(gen_stride * idx);
      hist_seed = jump.g * gen_seed0 + jump.c;
    end
    cur_seed = hist_seed;
    last_idx = idx;
    have_last = 1'b1;
    return hist_seed;
  endfunction

  function automatic logic [lcgsa_pkg::IDX_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[lcgsa_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [lcgsa_pkg::IDX_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0: return rand48();
      1: return lcgsa_pkg::IDX_W'($urandom_range(0, 2000));
      2: return ALL_ONES - lcgsa_pkg::IDX_W'($urandom_range(0, 6));
      default: return lcgsa_pkg::IDX_W'(1) << $urandom_range(0, lcgsa_pkg::IDX_W - 1);
    endcase
  endfunction

  function automatic void report_mismatch(input string what,
                                          input logic [lcgsa_pkg::VAL_W-1:0] exp_v,
                                          input logic [lcgsa_pkg::VAL_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, got_v);
  endfunction

  task automatic write_reg(input logic [lcgsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lcgsa_pkg::CFG_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      lcgsa_pkg::REG_MULT:   gen_mult   = d;
      lcgsa_pkg::REG_INC:    gen_inc    = d;
      lcgsa_pkg::REG_INIT:   gen_seed0  = d;
      lcgsa_pkg::REG_STRIDE: gen_stride = d;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [lcgsa_pkg::CFG_W-1:0] m,
                               input logic [lcgsa_pkg::CFG_W-1:0] c,
                               input logic [lcgsa_pkg::CFG_W-1:0] s0,
                               input logic [lcgsa_pkg::CFG_W-1:0] st);
    write_reg(lcgsa_pkg::REG_MULT, m);
    write_reg(lcgsa_pkg::REG_INC, c);
    write_reg(lcgsa_pkg::REG_INIT, s0);
    write_reg(lcgsa_pkg::REG_STRIDE, st);
    cfg_we <= 1'b0;
  endtask

  // Offers one request and books its expected value once the transfer happens.
  task automatic issue(input logic m, input logic [lcgsa_pkg::IDX_W-1:0] idx, input bit known,
                       input logic [lcgsa_pkg::VAL_W-1:0] known_value);
    logic [lcgsa_pkg::VAL_W-1:0] predicted;
    int unsigned                 gap;
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.history_index <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = lcg_response(m, idx);
    awaited_values.push_back(known ? known_value : predicted);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                                      : $urandom_range(0, 8));
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly runs of consecutive history starts with draws in between, plus noise.
  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned roll;
    int unsigned draws;
    sent = 0;
    // The first start of a phase usually follows the last index, so the stored stride is reused.
    if (have_last) begin
      run_idx  = last_idx;
      run_left = 2;
    end
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if (run_left == 0) begin
          run_idx  = pick_start();
          run_left = $urandom_range(3, 14);
        end else begin
          run_idx = run_idx + 48'd1;
          run_left--;
        end
        issue(lcgsa_pkg::MODE_HISTORY, run_idx, 1'b0, '0);
        draws = $urandom_range(0, 3);
        repeat (draws) issue(lcgsa_pkg::MODE_DRAW, rand48(), 1'b0, '0);
        sent += draws + 1;
      end else if (roll < 93) begin
        issue(lcgsa_pkg::MODE_DRAW, rand48(), 1'b0, '0);
        sent++;
      end else begin
        // Broken run: the same index again, or one step back.
        if (roll >= 97) run_idx = run_idx - 48'd1;
        issue(lcgsa_pkg::MODE_HISTORY, run_idx, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_values.size() == 0) begin
        report_mismatch("result with nothing awaited", 'x, out_ch.value);
      end else begin
        want = awaited_values.pop_front();
        if (out_ch.value !== want) report_mismatch("value mismatch", want, out_ch.value);
      end
    end
  end

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      // Long hold-offs let the block fill up and push back on the sender.
      if (cyc == 2500 || cyc == 40000 || cyc == 150000) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        cyc += 3000;
      end
      case ((cyc >> 7) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (cyc % 3 != 0);
      endcase
      @(posedge clk);
      cyc++;
    end
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= lcgsa_pkg::REG_MULT;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= lcgsa_pkg::MODE_DRAW;
    in_ch.history_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].known,
            directed_rows[i].value);
    random_phase(155);

    drain();
    apply_setting(48'd1, ALL_ONES, 48'd0, 48'd1);
    random_phase(155);

    drain();
    apply_setting(ALL_ONES, 48'd0, ALL_ONES, ALL_ONES);
    random_phase(155);

    drain();
    steady = 1'b1;
    apply_setting(rand48() | 48'd1, rand48(), rand48(), 48'd0);
    random_phase(155);

    drain();
    steady = 1'b0;
    apply_setting(rand48() | 48'd1, rand48(), rand48(),
                  lcgsa_pkg::CFG_W'($urandom_range(1, 1000)));
    random_phase(155);

    drain();
    apply_setting(lcgsa_pkg::MULT_RST, 48'd1, 48'd1, 48'h8000_0000_0000);
    random_phase(155);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_values.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== lcg_with_stride_skip_ahead.f =====
+incdir+design
design/lcgsa_pkg.sv
design/lcgsa_if.sv
design/lcgsa_mac.sv
design/lcg_with_stride_skip_ahead.sv
design/lcgsa_checker.sv
sim/testbench.sv
